/* hdl/bdwp_pkg.sv */
// Shared types and constants for the byte DMA word packer.
package bdwp_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_INT_START  = 3'd0;
    localparam logic [2:0] REG_EXT_START  = 3'd1;
    localparam logic [2:0] REG_PAGE       = 3'd2;
    localparam logic [2:0] REG_TYPE       = 3'd3;
    localparam logic [2:0] REG_WORD_COUNT = 3'd4;
    localparam logic [2:0] REG_RST_DONE   = 3'd5;
    localparam logic [2:0] REG_ROM_BANK   = 3'd6;

    // Transfer types
    localparam logic [1:0] TYPE_PROG    = 2'd0;
    localparam logic [1:0] TYPE_DATA    = 2'd1;
    localparam logic [1:0] TYPE_BYTE_HI = 2'd2;
    localparam logic [1:0] TYPE_BYTE_LO = 2'd3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int WADDR_W    = 14;
    localparam int WDATA_W    = 24;
    localparam int SRC_W      = 22;
    localparam int BANK_W     = 4;
    localparam int FULL_SRC_W = SRC_W + BANK_W;
    localparam int PAGE_W     = 8;

    typedef struct packed {
        logic                  write_valid;
        logic [WADDR_W-1:0]    write_addr;
        logic [WDATA_W-1:0]    write_data;
        logic                  to_program;
        logic [FULL_SRC_W-1:0] next_source_addr;
        logic                  last;
        logic [WADDR_W-1:0]    final_ext_addr;
        logic [PAGE_W-1:0]     final_page;
        logic                  reset_processor;
    } bdwp_result_t;

endpackage

/* hdl/bdwp_core.sv */
// Register file, transfer state and combinational byte packing datapath.
module bdwp_core import bdwp_pkg::*; #(
    parameter int ADDR_BITS = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  beat_in,
    input  logic [7:0]            rom_byte,
    output logic                  push,
    output bdwp_result_t          result
);

    logic [WADDR_W-1:0]   int_start_reg;
    logic [13:0]          ext_start_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [1:0]           type_reg;
    logic                 rst_done_reg;
    logic [BANK_W-1:0]    bank_reg;
    logic                 busy_reg;
    logic [1:0]           phase_reg;
    logic [15:0]          accum_reg;
    logic [ADDR_BITS-1:0] int_addr_reg;
    logic [13:0]          words_left_reg;
    logic [SRC_W-1:0]     src_addr_reg;

    logic [1:0]           need_bytes;
    logic [1:0]           phase_inc;
    logic                 word_done;
    logic                 is_last;
    logic [SRC_W-1:0]     src_inc;
    logic [ADDR_BITS-1:0] int_inc;
    logic [13:0]          wl_dec;
    logic [WDATA_W-1:0]   word;

    always_comb begin
        unique case (type_reg)
            TYPE_PROG:    need_bytes = 2'd3;
            TYPE_DATA:    need_bytes = 2'd2;
            TYPE_BYTE_HI,
            TYPE_BYTE_LO: need_bytes = 2'd1;
            default:      need_bytes = 2'd1;
        endcase
    end

    always_comb begin
        unique case (type_reg)
            TYPE_PROG:    word = {accum_reg, rom_byte};
            TYPE_DATA:    word = {8'h00, accum_reg[7:0], rom_byte};
            TYPE_BYTE_HI: word = {8'h00, rom_byte, 8'h00};
            TYPE_BYTE_LO: word = {16'h0000, rom_byte};
            default:      word = '0;
        endcase
    end

    assign phase_inc = phase_reg + 2'd1;
    assign word_done = (phase_inc >= need_bytes);
    assign src_inc   = src_addr_reg + SRC_W'(1);
    assign int_inc   = int_addr_reg + ADDR_BITS'(1);
    assign wl_dec    = words_left_reg - 14'd1;
    assign is_last   = word_done && (wl_dec == 14'd0);

    // A config write takes the cycle; a beat is only processed during a transfer
    assign push = beat_in && busy_reg && !cfg_we;

    always_comb begin
        result                  = '0;
        result.next_source_addr = {bank_reg, src_inc};
        if (word_done) begin
            result.write_valid = 1'b1;
            result.write_addr  = WADDR_W'(int_addr_reg);
            result.write_data  = word;
            result.to_program  = (type_reg == TYPE_PROG);
        end
        if (is_last) begin
            result.last            = 1'b1;
            result.final_ext_addr  = src_inc[13:0];
            result.final_page      = src_inc[SRC_W-1:14];
            result.reset_processor = rst_done_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_start_reg  <= '0;
            ext_start_reg  <= '0;
            page_reg       <= '0;
            type_reg       <= TYPE_PROG;
            rst_done_reg   <= 1'b0;
            bank_reg       <= '0;
            busy_reg       <= 1'b0;
            phase_reg      <= '0;
            accum_reg      <= '0;
            int_addr_reg   <= '0;
            words_left_reg <= '0;
            src_addr_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INT_START: if (!busy_reg) int_start_reg <= cfg_wdata;
                REG_EXT_START: if (!busy_reg) ext_start_reg <= cfg_wdata;
                REG_PAGE:      if (!busy_reg) page_reg <= cfg_wdata[PAGE_W-1:0];
                REG_TYPE:      if (!busy_reg) type_reg <= cfg_wdata[1:0];
                REG_WORD_COUNT: begin
                    // nonzero count starts (or restarts) a transfer
                    if (cfg_wdata != '0) begin
                        busy_reg       <= 1'b1;
                        phase_reg      <= '0;
                        accum_reg      <= '0;
                        words_left_reg <= cfg_wdata;
                        int_addr_reg   <= ADDR_BITS'(int_start_reg);
                        src_addr_reg   <= {page_reg, ext_start_reg};
                    end
                end
                REG_RST_DONE:  rst_done_reg <= cfg_wdata[0];
                REG_ROM_BANK:  bank_reg <= cfg_wdata[BANK_W-1:0];
                default: ;
            endcase
        end else if (push) begin
            src_addr_reg <= src_inc;
            if (!word_done) begin
                accum_reg <= {accum_reg[7:0], rom_byte};
                phase_reg <= phase_inc;
            end else begin
                phase_reg      <= '0;
                accum_reg      <= '0;
                int_addr_reg   <= int_inc;
                words_left_reg <= wl_dec;
                if (wl_dec == 14'd0) begin
                    // write back final addresses
                    busy_reg      <= 1'b0;
                    int_start_reg <= WADDR_W'(int_inc);
                    ext_start_reg <= src_inc[13:0];
                    page_reg      <= src_inc[SRC_W-1:14];
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (phase_reg < need_bytes))
        else $error("byte phase reached word size");
    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (phase_reg == 2'd0))
        else $error("byte phase nonzero while idle");
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && result.last) |=> !busy_reg)
        else $error("transfer still busy after last word");
`endif

endmodule

/* hdl/bdwp_skid.sv */
// Output register with skid stage for the result channel.
module bdwp_skid import bdwp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  bdwp_result_t push_data,
    output logic         push_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output bdwp_result_t m_data
);

    logic         main_valid_reg;
    logic         skid_valid_reg;
    bdwp_result_t main_reg;
    bdwp_result_t skid_reg;

    assign push_ready = !skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_data     = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !main_valid_reg) begin
            // advance: drain skid first, else take the new beat
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !main_valid_reg) begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid holds a beat while output is empty");
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (main_valid_reg && !m_ready && push) |=> skid_valid_reg)
        else $error("stalled beat not captured in skid");
`endif

endmodule

/* hdl/byte_dma_word_packer.sv */
// Byte DMA word packer: takes one ROM byte per beat (s_valid/s_ready) and,
// during a transfer, returns one result beat per byte with the next ROM source
// address and, when a word is complete, the packed word and its internal
// address. A transfer starts by writing a nonzero word_count on the config
// port; bytes offered while no transfer runs are taken and dropped. Throughput
// is one byte per clock while s_ready is high: the packing logic sits between
// the input handshake and a result register, so each result is registered
// before it appears on m_*. A two-entry output (result register plus skid
// stage) lets s_ready stay high while one finished result waits on m_ready.
// There is no post-reset clearing pass. ADDR_BITS sets the wrap width of the
// internal word address counter.
module byte_dma_word_packer import bdwp_pkg::*; #(
    parameter int ADDR_BITS = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rom_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_write_valid,
    output logic [WADDR_W-1:0]    m_write_addr,
    output logic [WDATA_W-1:0]    m_write_data,
    output logic                  m_to_program,
    output logic [FULL_SRC_W-1:0] m_next_source_addr,
    output logic                  m_last,
    output logic [WADDR_W-1:0]    m_final_ext_addr,
    output logic [PAGE_W-1:0]     m_final_page,
    output logic                  m_reset_processor
);

    logic         push;
    bdwp_result_t core_result;
    bdwp_result_t out_result;

    bdwp_core #(
        .ADDR_BITS(ADDR_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .beat_in  (s_valid && s_ready),
        .rom_byte (s_rom_byte),
        .push     (push),
        .result   (core_result)
    );

    bdwp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (core_result),
        .push_ready(s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_result)
    );

    assign m_write_valid      = out_result.write_valid;
    assign m_write_addr       = out_result.write_addr;
    assign m_write_data       = out_result.write_data;
    assign m_to_program       = out_result.to_program;
    assign m_next_source_addr = out_result.next_source_addr;
    assign m_last             = out_result.last;
    assign m_final_ext_addr   = out_result.final_ext_addr;
    assign m_final_page       = out_result.final_page;
    assign m_reset_processor  = out_result.reset_processor;

endmodule
